// File: src/bms_pkg.sv
// ----------------------------------------------------------------------------
// bms_pkg: shared types for the batch median select block
// Word formats of both channels and the control word of the radix select unit.
// ----------------------------------------------------------------------------
package bms_pkg;

  localparam int unsigned SampleW = 64;
  localparam int unsigned BitIdxW = 6;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic [SampleW-1:0] median;
    logic               dropped;
  } out_word_t;

  // Control word from the sequencer to the radix select unit.
  typedef struct packed {
    logic init;  // load target ranks and clear the prefixes
    logic acc;   // a stored sample is present on the data input
    logic step;  // end of a pass: settle one bit of each prefix
  } sel_ctrl_t;

endpackage

// File: src/bms_ram.sv
// ----------------------------------------------------------------------------
// bms_ram: generic simple dual-port RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module bms_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bms_radix_unit.sv
// ----------------------------------------------------------------------------
// bms_radix_unit: bitwise radix selection of two ranks
// Each pass over the stored samples counts, per target, the samples that
// match the settled prefix and hold a zero in the current bit; at the end of
// the pass that count settles the bit. Sixty-four passes give both values.
// ----------------------------------------------------------------------------
module bms_radix_unit #(
  parameter int unsigned CNT_W = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bms_pkg::sel_ctrl_t           ctrl_i,
  input  logic [bms_pkg::SampleW-1:0]  data_i,
  input  logic [CNT_W-1:0]             rank_lo_i,
  input  logic [CNT_W-1:0]             rank_hi_i,
  output logic [bms_pkg::SampleW-1:0]  value_lo_o,
  output logic [bms_pkg::SampleW-1:0]  value_hi_o
);
  import bms_pkg::*;

  logic [SampleW-1:0] bit_q;
  logic [SampleW-1:0] mask_q;
  logic [SampleW-1:0] pfx_q  [2];
  logic [CNT_W-1:0]   rank_q [2];
  logic [CNT_W-1:0]   cnt_q  [2];
  logic               hit    [2];

  always_comb begin
    for (int t = 0; t < 2; t++) begin
      hit[t] = (((data_i ^ pfx_q[t]) & mask_q) == '0) && ((data_i & bit_q) == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      mask_q <= '0;
      for (int t = 0; t < 2; t++) begin
        pfx_q[t]  <= '0;
        rank_q[t] <= '0;
        cnt_q[t]  <= '0;
      end
    end else if (ctrl_i.init) begin
      bit_q     <= {1'b1, {(SampleW-1){1'b0}}};
      mask_q    <= '0;
      rank_q[0] <= rank_lo_i;
      rank_q[1] <= rank_hi_i;
      for (int t = 0; t < 2; t++) begin
        pfx_q[t] <= '0;
        cnt_q[t] <= '0;
      end
    end else if (ctrl_i.step) begin
      bit_q  <= bit_q >> 1;
      mask_q <= mask_q | bit_q;
      for (int t = 0; t < 2; t++) begin
        cnt_q[t] <= '0;
        // At most as many zero-bit candidates as the remaining rank: the bit is one.
        if (rank_q[t] >= cnt_q[t]) begin
          pfx_q[t]  <= pfx_q[t] | bit_q;
          rank_q[t] <= rank_q[t] - cnt_q[t];
        end
      end
    end else if (ctrl_i.acc) begin
      for (int t = 0; t < 2; t++) begin
        if (hit[t]) begin
          cnt_q[t] <= cnt_q[t] + CNT_W'(1);
        end
      end
    end
  end

  assign value_lo_o = pfx_q[0];
  assign value_hi_o = pfx_q[1];

endmodule

// File: src/batch_median_select.sv
// ----------------------------------------------------------------------------
// batch_median_select: median of a batch of unsigned 64-bit samples
// Samples are stored one per word; after the last one a radix select finds
// the middle pair and the floored mean of that pair is returned.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+------------------------
//   in      | input     | in_valid_i/in_stall_o   | sample, last
//   out     | output    | out_valid_o/out_stall_i | median, dropped
//
// A batch of n stored samples is loaded word by word, then 64 passes are
// made over the sample RAM's single read port (n reads, a wait for the last
// read data, then a bit settled at the end), then ST_FINISH forms the mean.
// The input is stalled from the last sample until the result word is taken.
// Reset clears the state, the counters, the overflow flag and the result
// word; the sample RAM needs no clearing.
// ----------------------------------------------------------------------------
module batch_median_select #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bms_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bms_pkg::out_word_t  out_word_o
);
  import bms_pkg::*;

  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_FINISH,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [CW-1:0]    cnt_q;
  logic             ovf_q;
  logic [CW-1:0]    addr_q;
  logic             rd_vld_q;
  logic [BitIdxW-1:0] pass_q;
  out_word_t        out_q;

  logic             in_acc;
  logic             room;
  logic [CW-1:0]    n_next;
  logic [CW-1:0]    n_m1;
  logic             rd_en;
  logic             pass_end;
  sel_ctrl_t        ctrl;
  logic [SampleW-1:0] rd_data;
  logic [SampleW-1:0] val_lo;
  logic [SampleW-1:0] val_hi;
  logic [SampleW-1:0] mean;

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && (state_q == ST_LOAD);
  assign room       = (cnt_q < CW'(MAX_SAMPLES));
  assign n_next     = room ? (cnt_q + CW'(1)) : cnt_q;
  assign n_m1       = n_next - CW'(1);
  assign rd_en      = (state_q == ST_SCAN) && (addr_q != cnt_q);
  assign pass_end   = (state_q == ST_SCAN) && (addr_q == cnt_q) && !rd_vld_q;

  assign ctrl.init = in_acc && in_word_i.last;
  assign ctrl.acc  = rd_vld_q;
  assign ctrl.step = pass_end;

  bms_ram #(
    .WIDTH (SampleW),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && room),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (in_word_i.sample),
    .re_i    (rd_en),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  bms_radix_unit #(
    .CNT_W (CW)
  ) u_select (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .data_i     (rd_data),
    .rank_lo_i  (n_m1 >> 1),
    .rank_hi_i  (n_next >> 1),
    .value_lo_o (val_lo),
    .value_hi_o (val_hi)
  );

  // Floored mean without a 65-bit sum; an odd count selects the same rank twice.
  assign mean = (val_lo >> 1) + (val_hi >> 1) + {{(SampleW-1){1'b0}}, val_lo[0] & val_hi[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
      pass_q   <= '0;
      out_q    <= '0;
    end else begin
      rd_vld_q <= rd_en;
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            cnt_q <= n_next;
            if (!room) begin
              ovf_q <= 1'b1;
            end
            if (in_word_i.last) begin
              addr_q  <= '0;
              pass_q  <= '1;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            addr_q <= addr_q + CW'(1);
          end
          if (pass_end) begin
            addr_q <= '0;
            pass_q <= pass_q - BitIdxW'(1);
            if (pass_q == '0) begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          out_q.median  <= mean;
          out_q.dropped <= ovf_q;
          state_q       <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_stall_i) begin
            cnt_q   <= '0;
            ovf_q   <= 1'b0;
            state_q <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o = (state_q == ST_DONE);
  assign out_word_o  = out_q;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for batch_median_select
// Feeds batches of 64-bit samples, from hand-picked edge cases to long random
// streams and batches that overrun the sample store. Each batch's median is
// predicted on the input side and checked against the result words, with
// random sender bursts and receiver stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import bms_pkg::*;

  localparam int unsigned MaxSamples = 1024;
  localparam int unsigned IdleLimit  = 250000;
  localparam int unsigned RandWords  = 2000;

  typedef enum int unsigned {
    SmpFull,
    SmpNarrow,
    SmpTop,
    SmpFlat,
    SmpOneHot
  } sample_style_e;

  typedef enum int unsigned {
    StallNone,
    StallSparse,
    StallHeavy,
    StallSolid
  } stall_mode_e;

  typedef struct packed {
    in_word_t word;
    logic     hold;  // wait for all outstanding medians before sending
  } feed_item_t;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  in_word_t   in_word   = '0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  out_word_t  out_word;

  feed_item_t  feed_q[$];
  out_word_t   median_q[$];
  int unsigned words_queued = 0;
  int unsigned mismatches   = 0;
  int unsigned results_owed = 0;

  batch_median_select #(
    .MAX_SAMPLES(MaxSamples)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  task automatic push_word(input logic [63:0] s, input bit last_flag, input bit hold);
    feed_item_t item;
    item.word.sample = s;
    item.word.last   = last_flag;
    item.hold        = hold;
    feed_q.push_back(item);
    words_queued++;
  endtask

  task automatic add_batch(input int unsigned n, input sample_style_e style,
                           input bit hold);
    logic [63:0] flat;
    logic [63:0] s;
    flat = {$urandom, $urandom};
    for (int unsigned k = 0; k < n; k++) begin
      case (style)
        SmpFull:   s = {$urandom, $urandom};
        SmpNarrow: s = 64'($urandom_range(0, 7));
        SmpTop:    s = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 7));
        SmpFlat:   s = flat;
        default:   s = 64'd1 << $urandom_range(0, 63);
      endcase
      push_word(s, k == n - 1, hold && k == 0);
    end
  endtask

  // Stimulus and end of run.
  initial begin
    bit big_a_done;
    bit big_b_done;
    bit first;
    big_a_done = 1'b0;
    big_b_done = 1'b0;
    first      = 1'b1;

    // Single samples at both extremes.
    push_word(64'h0, 1'b1, 1'b0);
    push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    // Even pairs whose sum needs the 65th bit, and a pair that must round down.
    push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    push_word(64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0);
    push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    push_word(64'h1, 1'b0, 1'b0);
    push_word(64'h0, 1'b1, 1'b0);
    // Unsorted odd and even batches, then duplicates.
    push_word(64'd5, 1'b0, 1'b0);
    push_word(64'd3, 1'b0, 1'b0);
    push_word(64'd9, 1'b1, 1'b0);
    push_word(64'd7, 1'b0, 1'b0);
    push_word(64'd1, 1'b0, 1'b0);
    push_word(64'd8, 1'b0, 1'b0);
    push_word(64'd2, 1'b1, 1'b0);
    push_word(64'h8000_0000_0000_0000, 1'b0, 1'b0);
    push_word(64'h8000_0000_0000_0000, 1'b0, 1'b0);
    push_word(64'h8000_0000_0000_0000, 1'b1, 1'b0);

    while (words_queued < RandWords) begin
      // Two batches that overrun the store: one drops only the closing word,
      // the other drops the closing word and the two words before it.
      if (!big_a_done && words_queued > 200) begin
        add_batch(MaxSamples + 1, SmpFull, 1'b0);
        big_a_done = 1'b1;
      end else if (!big_b_done && words_queued > 1240) begin
        add_batch(MaxSamples + 3, sample_style_e'($urandom_range(0, 4)), 1'b0);
        big_b_done = 1'b1;
      end else begin
        add_batch(($urandom_range(0, 9) == 0) ? $urandom_range(13, 64)
                                               : $urandom_range(1, 12),
                  sample_style_e'($urandom_range(0, 4)),
                  first || ($urandom_range(0, 24) == 0));
        first = 1'b0;
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (feed_q.size() != 0 || in_valid);
    do @(negedge clk_i); while (results_owed != 0);
    repeat (200) @(negedge clk_i);
    if (median_q.size() != 0) begin
      note_mismatch("medians never delivered", 64'h0, 64'(median_q.size()));
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Sender: bursts of words with random gaps, holding a stalled word steady.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  feed_item_t  next_item;
  logic        send_now;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_word    <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!(in_valid && in_stall)) begin
      send_now = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (feed_q.size() != 0) begin
        // A word taken at this edge may close a batch, so a held word also waits for in_valid to be low.
        if (!feed_q[0].hold || (results_owed == 0 && !in_valid)) begin
          next_item = feed_q.pop_front();
          send_now  = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
      in_valid <= send_now;
      if (send_now) begin
        in_word <= next_item.word;
      end
    end
  end

  // Receiver: stall behavior changes in runs of random length.
  stall_mode_e stall_mode = StallNone;
  int unsigned stall_run  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else begin
      if (stall_run == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_run  = $urandom_range(8, 60);
      end
      stall_run--;
      case (stall_mode)
        StallNone:   out_stall <= 1'b0;
        StallSparse: out_stall <= ($urandom_range(0, 3) == 0);
        StallHeavy:  out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= 1'b1;
      endcase
    end
  end

  // Monitor: predicts each batch's median from the accepted words and checks
  // every result word against the oldest prediction.
  logic [63:0] batch_buf [MaxSamples];
  int unsigned batch_fill = 0;
  logic        batch_over = 1'b0;
  logic [63:0] sort_key;
  int          sort_j;
  logic [64:0] mid_sum;
  out_word_t   want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_fill = 0;
      batch_over = 1'b0;
      results_owed <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (median_q.size() == 0) begin
          note_mismatch("result word with no batch closed", 64'h0, out_word.median);
        end else begin
          want = median_q.pop_front();
          if (out_word.median !== want.median) begin
            note_mismatch("median", want.median, out_word.median);
          end
          if (out_word.dropped !== want.dropped) begin
            note_mismatch("dropped flag", 64'(want.dropped), 64'(out_word.dropped));
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (batch_fill < MaxSamples) begin
          batch_buf[batch_fill] = in_word.sample;
          batch_fill++;
        end else begin
          batch_over = 1'b1;
        end
        if (in_word.last) begin
          // The batch is finished, so it can be sorted in place.
          for (int i = 1; i < batch_fill; i++) begin
            sort_key = batch_buf[i];
            sort_j   = i;
            while (sort_j > 0 && batch_buf[sort_j-1] > sort_key) begin
              batch_buf[sort_j] = batch_buf[sort_j-1];
              sort_j--;
            end
            batch_buf[sort_j] = sort_key;
          end
          if (batch_fill % 2 == 1) begin
            want.median = batch_buf[batch_fill/2];
          end else begin
            mid_sum     = {1'b0, batch_buf[batch_fill/2-1]} + {1'b0, batch_buf[batch_fill/2]};
            want.median = mid_sum[64:1];
          end
          want.dropped = batch_over;
          median_q.push_back(want);
          batch_fill = 0;
          batch_over = 1'b0;
        end
      end
      results_owed <= median_q.size();
    end
  end

  // Watchdog on cycles with no word moving on either channel.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == IdleLimit) begin
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

endmodule

// File: sim.f
src/bms_pkg.sv
src/bms_ram.sv
src/bms_radix_unit.sv
src/batch_median_select.sv
tb/tb.sv
